[hdl/edrr_pkg.sv]
// Shared types and constants for the e-paper dirty-rectangle refresh policy.
// Holds the transaction structs, operation and reason codes, and reset values.
// No dependencies.
`default_nettype none

package edrr_pkg;

  // Operation codes carried by an input transaction.
  localparam logic [1:0] OP_STAGE   = 2'd0;
  localparam logic [1:0] OP_REQUEST = 2'd1;
  localparam logic [1:0] OP_DONE    = 2'd2;
  localparam logic [1:0] OP_FORCE   = 2'd3;

  // Outcome codes of a refresh-done transaction.
  localparam logic [1:0] OUTCOME_OK        = 2'd0;
  localparam logic [1:0] OUTCOME_FAILED    = 2'd1;
  localparam logic [1:0] OUTCOME_RECOVERED = 2'd2;

  // Reasons reported for a full refresh.
  localparam logic [2:0] REASON_NONE     = 3'd0;
  localparam logic [2:0] REASON_FORCED   = 3'd1;
  localparam logic [2:0] REASON_LIMIT    = 3'd2;
  localparam logic [2:0] REASON_RECT     = 3'd3;
  localparam logic [2:0] REASON_RECOVERY = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DISPLAY_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_DISPLAY_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_PARTIAL_CAP    = 2'd2;

  // Configuration reset values.
  localparam logic [10:0] DISPLAY_WIDTH_RST  = 11'd400;
  localparam logic [10:0] DISPLAY_HEIGHT_RST = 11'd300;
  localparam logic [7:0]  PARTIAL_CAP_RST    = 8'd10;

  // Saturation limits of the accumulated box; the width stays a multiple of eight.
  localparam logic [11:0] WIDTH_SAT  = 12'd2040;
  localparam logic [11:0] HEIGHT_SAT = 12'd2047;
  localparam logic [7:0]  TALLY_MAX  = 8'd255;

  typedef struct packed {
    logic [1:0]  operation;
    logic [9:0]  area_x;
    logic [9:0]  area_y;
    logic [10:0] area_w;
    logic [10:0] area_h;
    logic [1:0]  outcome;
  } edrr_in_t;

  typedef struct packed {
    logic [9:0]  dirty_left;
    logic [9:0]  dirty_top;
    logic [10:0] dirty_width;
    logic [10:0] dirty_height;
    logic        refresh_go;
    logic        full_refresh;
    logic [2:0]  full_cause;
    logic [7:0]  partial_tally;
    logic [7:0]  window_x_first_byte;
    logic [7:0]  window_x_last_byte;
    logic [10:0] window_y_last;
  } edrr_out_t;

  // Panel configuration as seen by the policy logic.
  typedef struct packed {
    logic [10:0] display_width;
    logic [10:0] display_height;
    logic [7:0]  partial_cap;
  } edrr_cfg_t;

endpackage

`default_nettype wire

[hdl/edrr_policy.sv]
// Dirty-rectangle accumulator and refresh decision for one transaction per cycle while accept is high.
// Holds the box and policy state; the result leaves combinationally to the buffer.
// Depends on edrr_pkg.
`default_nettype none

module edrr_policy
  import edrr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      accept,
  input  wire edrr_in_t  item,
  input  wire edrr_cfg_t cfg,
  output edrr_out_t      result
);

  logic [9:0]  acc_left_r, acc_left_nxt;
  logic [9:0]  acc_top_r, acc_top_nxt;
  logic [10:0] acc_width_r, acc_width_nxt;
  logic [10:0] acc_height_r, acc_height_nxt;
  logic        force_pending_r, force_pending_nxt;
  logic [7:0]  partial_counter_r, partial_counter_nxt;
  logic        awaiting_r, awaiting_nxt;
  logic        awaiting_full_r, awaiting_full_nxt;

  logic        acc_empty;
  logic [9:0]  x_aligned;
  logic [11:0] w_sum;
  logic [11:0] w_rounded;
  logic [9:0]  x0, y0;
  logic [11:0] ax, bx, ay, by, x1, y1;
  logic [11:0] w_union, h_union;
  logic [11:0] w_new, h_new;
  logic [2:0]  reason;
  logic        rect_is_full;
  logic [11:0] x_end;
  logic [10:0] y_end;
  logic [10:0] dw_minus1;

  // Staged rectangle alignment and bounding-box union.
  always_comb begin
    acc_empty = (acc_width_r == 11'd0) || (acc_height_r == 11'd0);
    x_aligned = {item.area_x[9:3], 3'b000};
    w_sum     = {1'b0, item.area_w} + 12'd7;
    w_rounded = {w_sum[11:3], 3'b000};
    x0 = (acc_left_r < x_aligned) ? acc_left_r : x_aligned;
    y0 = (acc_top_r < item.area_y) ? acc_top_r : item.area_y;
    ax = {2'b00, acc_left_r} + {1'b0, acc_width_r};
    bx = {2'b00, x_aligned} + w_rounded;
    ay = {2'b00, acc_top_r} + {1'b0, acc_height_r};
    by = {2'b00, item.area_y} + {1'b0, item.area_h};
    x1 = (ax > bx) ? ax : bx;
    y1 = (ay > by) ? ay : by;
    w_union = x1 - {2'b00, x0};
    h_union = y1 - {2'b00, y0};
    w_new = acc_empty ? w_rounded : w_union;
    h_new = acc_empty ? {1'b0, item.area_h} : h_union;
  end

  // Refresh decision and RAM window terms of the stored box.
  always_comb begin
    rect_is_full = (acc_left_r == 10'd0) && (acc_top_r == 10'd0) &&
                   (acc_width_r == cfg.display_width) &&
                   (acc_height_r == cfg.display_height);
    if (force_pending_r) begin
      reason = REASON_FORCED;
    end else if (partial_counter_r >= cfg.partial_cap) begin
      reason = REASON_LIMIT;
    end else if (rect_is_full) begin
      reason = REASON_RECT;
    end else begin
      reason = REASON_NONE;
    end
    x_end     = {2'b00, acc_left_r} + {1'b0, acc_width_r} - 12'd1;
    y_end     = {1'b0, acc_top_r} + acc_height_r - 11'd1;
    dw_minus1 = cfg.display_width - 11'd1;
  end

  // Next state and result of the current transaction.
  always_comb begin
    acc_left_nxt        = acc_left_r;
    acc_top_nxt         = acc_top_r;
    acc_width_nxt       = acc_width_r;
    acc_height_nxt      = acc_height_r;
    force_pending_nxt   = force_pending_r;
    partial_counter_nxt = partial_counter_r;
    awaiting_nxt        = awaiting_r;
    awaiting_full_nxt   = awaiting_full_r;
    result              = '0;

    case (item.operation)
      OP_STAGE: begin
        if ((item.area_w != 11'd0) && (item.area_h != 11'd0)) begin
          acc_left_nxt   = acc_empty ? x_aligned : x0;
          acc_top_nxt    = acc_empty ? item.area_y : y0;
          acc_width_nxt  = (w_new > WIDTH_SAT) ? WIDTH_SAT[10:0] : w_new[10:0];
          acc_height_nxt = (h_new > HEIGHT_SAT) ? HEIGHT_SAT[10:0] : h_new[10:0];
        end
      end
      OP_REQUEST: begin
        if (!acc_empty) begin
          result.refresh_go   = 1'b1;
          result.full_refresh = (reason != REASON_NONE);
          result.full_cause   = reason;
          if (reason != REASON_NONE) begin
            result.window_x_first_byte = 8'd0;
            result.window_x_last_byte  = dw_minus1[10:3];
            result.window_y_last       = cfg.display_height - 11'd1;
          end else begin
            result.window_x_first_byte = {1'b0, acc_left_r[9:3]};
            result.window_x_last_byte  = x_end[10:3];
            result.window_y_last       = y_end;
          end
          acc_left_nxt      = 10'd0;
          acc_top_nxt       = 10'd0;
          acc_width_nxt     = 11'd0;
          acc_height_nxt    = 11'd0;
          awaiting_nxt      = 1'b1;
          awaiting_full_nxt = (reason != REASON_NONE);
        end
      end
      OP_DONE: begin
        if (awaiting_r) begin
          if (item.outcome == OUTCOME_OK) begin
            force_pending_nxt = 1'b0;
            if (awaiting_full_r) begin
              partial_counter_nxt = 8'd0;
              result.full_refresh = 1'b1;
            end else if (partial_counter_r != TALLY_MAX) begin
              partial_counter_nxt = partial_counter_r + 8'd1;
            end
          end else if (item.outcome == OUTCOME_RECOVERED) begin
            force_pending_nxt   = 1'b0;
            partial_counter_nxt = 8'd0;
            result.full_refresh = 1'b1;
            result.full_cause   = REASON_RECOVERY;
          end
          awaiting_nxt = 1'b0;
        end
      end
      OP_FORCE: begin
        force_pending_nxt = 1'b1;
      end
      default: begin
        force_pending_nxt = force_pending_r;
      end
    endcase

    // A request that goes ahead shows the box it took; all others show the box after.
    if ((item.operation == OP_REQUEST) && !acc_empty) begin
      result.dirty_left   = acc_left_r;
      result.dirty_top    = acc_top_r;
      result.dirty_width  = acc_width_r;
      result.dirty_height = acc_height_r;
    end else begin
      result.dirty_left   = acc_left_nxt;
      result.dirty_top    = acc_top_nxt;
      result.dirty_width  = acc_width_nxt;
      result.dirty_height = acc_height_nxt;
    end
    result.partial_tally = partial_counter_nxt;
  end

  // State update on each accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_left_r        <= 10'd0;
      acc_top_r         <= 10'd0;
      acc_width_r       <= 11'd0;
      acc_height_r      <= 11'd0;
      force_pending_r   <= 1'b0;
      partial_counter_r <= 8'd0;
      awaiting_r        <= 1'b0;
      awaiting_full_r   <= 1'b0;
    end else if (accept) begin
      acc_left_r        <= acc_left_nxt;
      acc_top_r         <= acc_top_nxt;
      acc_width_r       <= acc_width_nxt;
      acc_height_r      <= acc_height_nxt;
      force_pending_r   <= force_pending_nxt;
      partial_counter_r <= partial_counter_nxt;
      awaiting_r        <= awaiting_nxt;
      awaiting_full_r   <= awaiting_full_nxt;
    end
  end

endmodule

`default_nettype wire

[hdl/edrr_obuf.sv]
// Two-entry output buffer: a result register plus a skid register.
// Lets the policy accept a transaction while one result waits downstream.
// Depends on edrr_pkg.
`default_nettype none

module edrr_obuf
  import edrr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire edrr_out_t push_data,
  output logic           full,
  output logic           out_valid,
  input  wire logic      out_stall,
  output edrr_out_t      out_data
);

  logic      main_valid_r, main_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  edrr_out_t main_r, main_nxt;
  edrr_out_t skid_r, skid_nxt;
  logic      taken;

  assign taken     = main_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  // The skid entry only fills when the result register is held by a stall.
  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (taken) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || taken) begin
        main_nxt       = push_data;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (taken) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

`default_nettype wire

[hdl/epaper_dirty_rect_refresh_policy_core.sv]
// Top level of the e-paper dirty-rectangle refresh policy.
// Instantiates edrr_policy and edrr_obuf; depends on edrr_pkg.
//
// Usage: the input channel (in_valid, in_stall, in_data) carries one
// transaction per operation: stage a rectangle, request a refresh, report a
// refresh done, or force a full refresh. Every input transaction produces
// exactly one result transaction on the output channel (out_valid,
// out_stall, out_data), in order.
// The policy state updates in the cycle of acceptance and the result is
// registered in the output buffer before it is offered on out_data.
// Throughput is one transaction per cycle while in_stall is low; the decision is a single pass of
// compare, add and min/max logic on the stored box.
// A two-entry output buffer holds results while the receiver stalls; the
// input stays open while one result waits and raises in_stall only once
// both entries are full.
// The write port (cfg_we, cfg_index, cfg_wdata) sets panel width, panel
// height and the partial-refresh limit; write it only while idle.
// Synchronous reset clears the box, counters, flags and the output buffer
// and restores the default panel configuration.
`default_nettype none

module epaper_dirty_rect_refresh_policy_core
  import edrr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire edrr_in_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output edrr_out_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [10:0] cfg_wdata
);

  edrr_cfg_t cfg_r;
  edrr_out_t result;
  logic      accept;
  logic      buf_full;

  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  // Configuration registers; an unused index is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.display_width  <= DISPLAY_WIDTH_RST;
      cfg_r.display_height <= DISPLAY_HEIGHT_RST;
      cfg_r.partial_cap    <= PARTIAL_CAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DISPLAY_WIDTH:  cfg_r.display_width  <= cfg_wdata;
        CFG_DISPLAY_HEIGHT: cfg_r.display_height <= cfg_wdata;
        CFG_PARTIAL_CAP:    cfg_r.partial_cap    <= cfg_wdata[7:0];
        default:            cfg_r <= cfg_r;
      endcase
    end
  end

  edrr_policy u_policy (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_data),
    .cfg    (cfg_r),
    .result (result)
  );

  edrr_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[hdl/edrr_checker.sv]
// Port-level checks for the e-paper dirty-rectangle refresh policy.
// Bound to epaper_dirty_rect_refresh_policy_core; depends on edrr_pkg.
`default_nettype none

module edrr_checker
  import edrr_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire edrr_out_t out_data
);

  // A stalled result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // An accepted transaction always leaves a result pending in the next cycle.
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted transaction produced no result");

  // The RAM window is zero unless a refresh goes ahead.
  a_window_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.refresh_go |->
      (out_data.window_x_first_byte == 8'd0) && (out_data.window_x_last_byte == 8'd0) &&
      (out_data.window_y_last == 11'd0))
    else $error("window set without refresh");

  // A go decision is full exactly when it carries a reason.
  a_reason_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.refresh_go |->
      (out_data.full_refresh == (out_data.full_cause != REASON_NONE)))
    else $error("full refresh flag disagrees with reason");

  // Reset empties the output buffer.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("output buffer not empty after reset");

endmodule

bind epaper_dirty_rect_refresh_policy_core edrr_checker u_edrr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

[tb/sv/refresh_decision_checker.sv]
// Result checker for the e-paper dirty-rectangle refresh policy core.
// Watches the input, result and write ports, predicts each result and compares it.
// Depends on edrr_pkg.
`timescale 1ns / 100ps

module refresh_decision_checker
  import edrr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  edrr_in_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  edrr_out_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_wdata,
  output int          fail_count,
  output int          awaited_count,
  output int          results_checked,
  output int          full_seen,
  output int          partial_seen
);

  // Panel settings as the block should hold them.
  logic [10:0] panel_w;
  logic [10:0] panel_h;
  logic [7:0]  limit_partials;

  // Policy state as the block should hold it.
  logic [9:0]  box_left;
  logic [9:0]  box_top;
  logic [10:0] box_w;
  logic [10:0] box_h;
  logic        force_armed;
  logic [7:0]  partial_run;
  logic        outcome_due;
  logic        due_full;

  // Results predicted but not yet seen, oldest first.
  edrr_out_t expected_results[$];

  int fails;
  int checked;
  int fulls;
  int partials;

  initial begin
    fails = 0;
    checked = 0;
    fulls = 0;
    partials = 0;
  end

  function automatic void clear_state();
    panel_w = DISPLAY_WIDTH_RST;
    panel_h = DISPLAY_HEIGHT_RST;
    limit_partials = PARTIAL_CAP_RST;
    box_left = '0;
    box_top = '0;
    box_w = '0;
    box_h = '0;
    force_armed = 1'b0;
    partial_run = '0;
    outcome_due = 1'b0;
    due_full = 1'b0;
  endfunction

  // Applies one transaction to the predicted state and returns the result it causes.
  function automatic edrr_out_t policy_result(edrr_in_t t);
    edrr_out_t r;
    int x, w, h, x0, y0, x1, y1, span;
    logic [2:0] why;
    logic [10:0] last_col;
    r = '0;
    case (t.operation)
      OP_STAGE: begin
        if (t.area_w != 0 && t.area_h != 0) begin
          // Left edge down to a byte boundary, width up to whole bytes.
          x = {t.area_x[9:3], 3'b000};
          w = ((int'(t.area_w) + 7) / 8) * 8;
          h = int'(t.area_h);
          if (box_w == 0 || box_h == 0) begin
            box_left = x[9:0];
            box_top = t.area_y;
          end else begin
            x0 = (int'(box_left) < x) ? int'(box_left) : x;
            y0 = (int'(box_top) < int'(t.area_y)) ? int'(box_top) : int'(t.area_y);
            x1 = int'(box_left) + int'(box_w);
            if (x + w > x1) x1 = x + w;
            y1 = int'(box_top) + int'(box_h);
            if (int'(t.area_y) + h > y1) y1 = int'(t.area_y) + h;
            box_left = x0[9:0];
            box_top = y0[9:0];
            w = x1 - x0;
            h = y1 - y0;
          end
          box_w = (w > int'(WIDTH_SAT)) ? WIDTH_SAT[10:0] : 11'(w);
          box_h = (h > int'(HEIGHT_SAT)) ? HEIGHT_SAT[10:0] : 11'(h);
        end
      end
      OP_REQUEST: begin
        if (box_w != 0 && box_h != 0) begin
          // Full refresh reasons are checked in priority order.
          if (force_armed) why = REASON_FORCED;
          else if (partial_run >= limit_partials) why = REASON_LIMIT;
          else if (box_left == 0 && box_top == 0 && box_w == panel_w && box_h == panel_h)
            why = REASON_RECT;
          else why = REASON_NONE;
          r.dirty_left = box_left;
          r.dirty_top = box_top;
          r.dirty_width = box_w;
          r.dirty_height = box_h;
          r.refresh_go = 1'b1;
          r.full_refresh = (why != REASON_NONE);
          r.full_cause = why;
          if (r.full_refresh) begin
            last_col = panel_w - 11'd1;
            r.window_x_first_byte = '0;
            r.window_x_last_byte = last_col[10:3];
            r.window_y_last = panel_h - 11'd1;
          end else begin
            span = int'(box_left) + int'(box_w) - 1;
            r.window_x_first_byte = {1'b0, box_left[9:3]};
            r.window_x_last_byte = 8'(span >> 3);
            r.window_y_last = 11'(int'(box_top) + int'(box_h) - 1);
          end
          box_left = '0;
          box_top = '0;
          box_w = '0;
          box_h = '0;
          outcome_due = 1'b1;
          due_full = r.full_refresh;
        end
      end
      OP_DONE: begin
        // Outcomes only count while a refresh is outstanding.
        if (outcome_due) begin
          if (t.outcome == OUTCOME_OK) begin
            force_armed = 1'b0;
            if (due_full) begin
              partial_run = '0;
              r.full_refresh = 1'b1;
            end else if (partial_run != TALLY_MAX) begin
              partial_run = partial_run + 8'd1;
            end
          end else if (t.outcome == OUTCOME_RECOVERED) begin
            force_armed = 1'b0;
            partial_run = '0;
            r.full_refresh = 1'b1;
            r.full_cause = REASON_RECOVERY;
          end
          outcome_due = 1'b0;
        end
      end
      default: begin
        force_armed = 1'b1;
      end
    endcase
    if (!r.refresh_go) begin
      r.dirty_left = box_left;
      r.dirty_top = box_top;
      r.dirty_width = box_w;
      r.dirty_height = box_h;
    end
    r.partial_tally = partial_run;
    return r;
  endfunction

  // Lists every field that differs, with expected and actual values.
  function automatic string describe_diffs(edrr_out_t e, edrr_out_t a);
    string s;
    s = "";
    if (e.dirty_left !== a.dirty_left)
      s = {s, $sformatf(" dirty_left %0d/%0d", e.dirty_left, a.dirty_left)};
    if (e.dirty_top !== a.dirty_top)
      s = {s, $sformatf(" dirty_top %0d/%0d", e.dirty_top, a.dirty_top)};
    if (e.dirty_width !== a.dirty_width)
      s = {s, $sformatf(" dirty_width %0d/%0d", e.dirty_width, a.dirty_width)};
    if (e.dirty_height !== a.dirty_height)
      s = {s, $sformatf(" dirty_height %0d/%0d", e.dirty_height, a.dirty_height)};
    if (e.refresh_go !== a.refresh_go)
      s = {s, $sformatf(" refresh_go %0d/%0d", e.refresh_go, a.refresh_go)};
    if (e.full_refresh !== a.full_refresh)
      s = {s, $sformatf(" full_refresh %0d/%0d", e.full_refresh, a.full_refresh)};
    if (e.full_cause !== a.full_cause)
      s = {s, $sformatf(" full_cause %0d/%0d", e.full_cause, a.full_cause)};
    if (e.partial_tally !== a.partial_tally)
      s = {s, $sformatf(" partial_tally %0d/%0d", e.partial_tally, a.partial_tally)};
    if (e.window_x_first_byte !== a.window_x_first_byte)
      s = {s, $sformatf(" x_first %0d/%0d", e.window_x_first_byte, a.window_x_first_byte)};
    if (e.window_x_last_byte !== a.window_x_last_byte)
      s = {s, $sformatf(" x_last %0d/%0d", e.window_x_last_byte, a.window_x_last_byte)};
    if (e.window_y_last !== a.window_y_last)
      s = {s, $sformatf(" y_last %0d/%0d", e.window_y_last, a.window_y_last)};
    return s;
  endfunction

  function automatic void note_failure(string what);
    fails++;
    if (fails <= 10) $display("[%0t] mismatch (expected/actual):%s", $time, what);
  endfunction

  // Results are matched first; a transaction taken at this edge still sees the
  // panel settings from before any write at the same edge.
  always @(posedge clk) begin : watch
    edrr_out_t want;
    string diffs;
    if (!rst_n) begin
      clear_state();
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          note_failure($sformatf(" result with nothing pending, data %h", out_data));
        end else begin
          want = expected_results.pop_front();
          diffs = describe_diffs(want, out_data);
          if (diffs != "") note_failure(diffs);
          checked++;
          if (want.refresh_go && want.full_refresh) fulls++;
          else if (want.refresh_go) partials++;
        end
      end
      if (in_valid && !in_stall) expected_results.push_back(policy_result(in_data));
      if (cfg_we) begin
        case (cfg_index)
          CFG_DISPLAY_WIDTH:  panel_w = cfg_wdata;
          CFG_DISPLAY_HEIGHT: panel_h = cfg_wdata;
          CFG_PARTIAL_CAP:    limit_partials = cfg_wdata[7:0];
          default: ;
        endcase
      end
    end
    fail_count <= fails;
    awaited_count <= expected_results.size();
    results_checked <= checked;
    full_seen <= fulls;
    partial_seen <= partials;
  end

endmodule

[tb/sv/tb.sv]
// Testbench top for the e-paper dirty-rectangle refresh policy core.
// Drives transactions, panel settings and result back-pressure; the verdict comes
// from refresh_decision_checker. Depends on edrr_pkg and the core.
`timescale 1ns / 100ps

module tb;
  import edrr_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASE_ITEMS = 180;
  localparam logic [1:0] OUTCOME_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  edrr_in_t    in_data;
  logic        out_valid;
  logic        out_stall;
  edrr_out_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [10:0] cfg_wdata;

  int fail_count;
  int awaited_count;
  int results_checked;
  int full_seen;
  int partial_seen;

  int          items_sent = 0;
  int          settings_used = 1;
  int          cycle_count = 0;
  logic [10:0] cur_w = DISPLAY_WIDTH_RST;
  logic [10:0] cur_h = DISPLAY_HEIGHT_RST;
  logic        quiet_pacing;
  logic        hold_off_req;

  always #5 clk = ~clk;

  epaper_dirty_rect_refresh_policy_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  refresh_decision_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .awaited_count   (awaited_count),
    .results_checked (results_checked),
    .full_seen       (full_seen),
    .partial_seen    (partial_seen)
  );

  // Mostly short pauses, now and then a long one.
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // A transaction with every field random.
  function automatic edrr_in_t random_raw();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[$bits(edrr_in_t)-1:0];
  endfunction

  function automatic edrr_in_t command(logic [1:0] op, logic [1:0] oc);
    edrr_in_t t;
    t = random_raw();
    t.operation = op;
    t.outcome = oc;
    return t;
  endfunction

  function automatic edrr_in_t stage_at(logic [9:0] x, logic [9:0] y,
                                        logic [10:0] w, logic [10:0] h);
    edrr_in_t t;
    t = command(OP_STAGE, 2'($urandom_range(0, 3)));
    t.area_x = x;
    t.area_y = y;
    t.area_w = w;
    t.area_h = h;
    return t;
  endfunction

  // Stage content: mostly small boxes, some empty, oversized or whole-panel ones.
  function automatic edrr_in_t random_stage();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return stage_at(10'd0, 10'd0, cur_w, cur_h);
    if (r < 14) return stage_at(10'($urandom), 10'($urandom),
                                11'($urandom_range(0, 1)) * 11'($urandom),
                                (r < 11) ? 11'd0 : 11'($urandom));
    if (r < 24) return stage_at(10'($urandom), 10'($urandom), 11'($urandom), 11'($urandom));
    return stage_at(10'($urandom), 10'($urandom), 11'($urandom_range(1, 64)),
                    11'($urandom_range(1, 48)));
  endfunction

  function automatic logic [1:0] random_outcome();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return OUTCOME_OK;
    if (r < 85) return OUTCOME_FAILED;
    if (r < 95) return OUTCOME_RECOVERED;
    return OUTCOME_UNUSED;
  endfunction

  // Offers one transaction and returns at the edge where it is taken.
  task automatic offer(input edrr_in_t item);
    int gap;
    gap = 0;
    if (!quiet_pacing && $urandom_range(0, 2) == 0) gap = gap_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Stops offering and waits until every predicted result has been seen.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_count != 0);
    repeat (3) @(posedge clk);
  endtask

  // Writes all three panel registers on consecutive cycles.
  task automatic load_panel(input logic [10:0] w, input logic [10:0] h, input logic [7:0] lim);
    cfg_we <= 1'b1;
    cfg_index <= CFG_DISPLAY_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= CFG_DISPLAY_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_index <= CFG_PARTIAL_CAP;
    cfg_wdata <= {3'b000, lim};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_w = w;
    cur_h = h;
    settings_used++;
  endtask

  // One stage-request-done cycle as firmware would issue it.
  task automatic refresh_round();
    int stages;
    stages = $urandom_range(1, 4);
    repeat (stages) offer(random_stage());
    if ($urandom_range(0, 5) == 0) offer(command(OP_FORCE, 2'($urandom)));
    offer(command(OP_REQUEST, 2'($urandom)));
    if ($urandom_range(0, 9) != 0) offer(command(OP_DONE, random_outcome()));
  endtask

  task automatic random_phase(input int quota);
    int start;
    start = items_sent;
    while (items_sent - start < quota) begin
      if ($urandom_range(0, 3) == 0) offer(random_raw());
      else refresh_round();
    end
  endtask

  // Short directed sequence at the reset panel settings.
  task automatic directed_checks();
    offer(command(OP_DONE, OUTCOME_OK));          // outcome with nothing outstanding
    offer(command(OP_REQUEST, OUTCOME_OK));       // request with an empty box
    offer(stage_at(10'd1023, 10'd1023, 11'd0, 11'd5));
    offer(stage_at(10'd0, 10'd0, 11'd7, 11'd0));
    offer(stage_at(10'd13, 10'd7, 11'd1, 11'd1)); // aligned down and rounded up
    offer(stage_at(10'd1023, 10'd1023, 11'd1024, 11'd1024));
    offer(stage_at(10'd0, 10'd0, 11'd2047, 11'd2047)); // union saturates
    offer(command(OP_REQUEST, OUTCOME_OK));
    offer(stage_at(10'd5, 10'd3, 11'd9, 11'd2));
    offer(command(OP_REQUEST, OUTCOME_OK));       // replaces the outstanding refresh
    offer(command(OP_DONE, OUTCOME_OK));
    offer(command(OP_FORCE, OUTCOME_OK));
    offer(stage_at(10'd0, 10'd0, cur_w, cur_h));
    offer(command(OP_REQUEST, OUTCOME_OK));       // forced full refresh
    offer(command(OP_DONE, OUTCOME_OK));
    offer(stage_at(10'd0, 10'd0, cur_w, cur_h));
    offer(command(OP_REQUEST, OUTCOME_OK));       // box covers the panel
    offer(command(OP_DONE, OUTCOME_FAILED));
    offer(command(OP_DONE, OUTCOME_RECOVERED));   // ignored, nothing outstanding
    offer(stage_at(10'd1016, 10'd1000, 11'd8, 11'd24));
    offer(command(OP_REQUEST, OUTCOME_OK));
    offer(command(OP_DONE, OUTCOME_RECOVERED));
    offer(stage_at(10'd64, 10'd64, 11'd16, 11'd16));
    offer(command(OP_REQUEST, OUTCOME_OK));
    offer(command(OP_DONE, OUTCOME_UNUSED));
  endtask

  // Receiver back-pressure, including one long hold-off on request.
  initial begin : sink_pacing
    bit held;
    int burst;
    held = 1'b0;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (quiet_pacing || $urandom_range(0, 3) != 0) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        burst = gap_length();
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
      end
    end
  end

  // Watchdog on total run length.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run stopped after %0d cycles with %0d results pending.",
             cycle_count, awaited_count);
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_DISPLAY_WIDTH;
    cfg_wdata <= '0;
    quiet_pacing <= 1'b0;
    hold_off_req <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_checks();
    random_phase(PHASE_ITEMS);

    // Smallest non-zero panel and limit, with the long receiver hold-off.
    settle();
    load_panel(11'd8, 11'd1, 8'd1);
    hold_off_req <= 1'b1;
    random_phase(PHASE_ITEMS);

    // Largest panel and limit.
    settle();
    load_panel(11'd1024, 11'd1024, 8'd255);
    random_phase(PHASE_ITEMS);

    // Zero-size panel and zero limit: windows wrap and every refresh is full.
    settle();
    load_panel(11'd0, 11'd0, 8'd0);
    random_phase(PHASE_ITEMS);

    // Random panels; the first one runs back to back without pauses.
    settle();
    quiet_pacing <= 1'b1;
    load_panel(11'(8 * $urandom_range(1, 128)), 11'($urandom_range(1, 1024)),
               8'($urandom_range(1, 12)));
    random_phase(PHASE_ITEMS);
    settle();
    quiet_pacing <= 1'b0;
    repeat (2) begin
      load_panel(11'(8 * $urandom_range(1, 128)), 11'($urandom_range(1, 1024)),
                 8'($urandom_range(1, 12)));
      random_phase(PHASE_ITEMS);
      settle();
    end

    repeat (10) @(posedge clk);
    $display("Sent %0d transactions over %0d panel settings, zero-size and extremes included.",
             items_sent, settings_used);
    $display("Checked %0d results: %0d full and %0d partial refreshes, %0d mismatches.",
             results_checked, full_seen, partial_seen, fail_count);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
